FILE: design/sukt_pkg.sv
// Shared types, sizes and codes for the sorted unique key table.
package sukt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int RPT_W    = 7;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_DUP    = 3'd1,
		ST_ABSENT = 3'd2,
		ST_FULL   = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [RPT_W-1:0] position;
		logic [RPT_W-1:0] entry_count;
	} rsp_t;

endpackage

FILE: design/sukt_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module sukt_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/sukt_obuf.sv
// Result register that decouples the core from a stalled result channel.
module sukt_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sukt_pkg::rsp_t push_rsp,
	output logic          push_ready,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sukt_pkg::rsp_t rsp
);
	import sukt_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign push_ready = !valid_q || !rsp_stall;
	assign rsp_valid  = valid_q;
	assign rsp        = data_q;

	// load on push, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && push_ready) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			data_q <= push_rsp;
		end
	end

endmodule

FILE: design/sukt_core.sv
// Command sequencer: binary search over the key RAM, then shift and write back.
module sukt_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  sukt_pkg::req_t             req,
	output logic                       push,
	output sukt_pkg::rsp_t             push_rsp,
	input  logic                       push_ready,
	output logic                       ram_wr_en,
	output logic [sukt_pkg::IDX_W-1:0] ram_wr_addr,
	output logic [sukt_pkg::KEY_W-1:0] ram_wr_data,
	output logic                       ram_rd_en,
	output logic [sukt_pkg::IDX_W-1:0] ram_rd_addr,
	input  logic [sukt_pkg::KEY_W-1:0] ram_rd_data
);
	import sukt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PROBE = 6'b000010,
		S_CMP   = 6'b000100,
		S_SHIFT = 6'b001000,
		S_FIN   = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic                    rd_act_q;
	logic                    mv_s1;
	logic [IDX_W-1:0]        addr_s1;

	cmd_t                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hi_q;
	logic [IDX_W-1:0]        mid_q;
	logic                    found_q;
	logic [IDX_W-1:0]        slot_q;
	logic [IDX_W-1:0]        rd_ptr_q;
	logic [IDX_W-1:0]        stop_q;
	status_t                 status_q;
	logic [RPT_W-1:0]        pos_q;

	logic                    accept;
	logic [CNT_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid_w;
	logic [CNT_W-1:0]        lo_plus1;
	logic                    key_lt;
	logic                    key_eq;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w     = mid_sum[IDX_W:1];
	assign lo_plus1  = lo_q + CNT_W'(1);
	assign key_lt    = $signed(ram_rd_data) < key_q;
	assign key_eq    = $signed(ram_rd_data) == key_q;

	// drive the RAM ports; shift reads and writes never hit the same entry
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = rd_ptr_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = addr_s1;
		ram_wr_data = ram_rd_data;
		case (state_q)
			S_PROBE: begin
				ram_rd_en   = (lo_q < hi_q);
				ram_rd_addr = mid_w;
			end
			S_SHIFT: begin
				ram_rd_en = rd_act_q;
				ram_wr_en = mv_s1;
			end
			S_FIN: begin
				ram_wr_en   = (cmd_q == CMD_INSERT);
				ram_wr_addr = slot_q;
				ram_wr_data = key_q;
			end
			default: begin
			end
		endcase
	end

	// present the result
	assign push                 = (state_q == S_RESP);
	assign push_rsp.status      = status_q;
	assign push_rsp.position    = pos_q;
	assign push_rsp.entry_count = RPT_W'(count_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_act_q <= 1'b0;
			mv_s1    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
							end
							CMD_INSERT: begin
								state_q <= (count_q >= CNT_W'(CAPACITY)) ? S_RESP : S_PROBE;
							end
							default: begin
								state_q <= (count_q == '0) ? S_RESP : S_PROBE;
							end
						endcase
					end
				end
				S_PROBE: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else begin
						case (cmd_q)
							CMD_INSERT: begin
								if (found_q) begin
									state_q <= S_RESP;
								end else begin
									state_q  <= S_SHIFT;
									rd_act_q <= (lo_q != count_q);
								end
							end
							CMD_DELETE: begin
								if (!found_q) begin
									state_q <= S_RESP;
								end else begin
									state_q  <= S_SHIFT;
									rd_act_q <= (lo_plus1 != count_q);
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_CMP: begin
					state_q <= S_PROBE;
				end
				S_SHIFT: begin
					mv_s1 <= rd_act_q;
					if (rd_act_q && (rd_ptr_q == stop_q)) begin
						rd_act_q <= 1'b0;
					end
					if (!rd_act_q && !mv_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd_q == CMD_INSERT) begin
						count_q <= count_q + CNT_W'(1);
					end else begin
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (push_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// search bounds, shift pointers and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q    <= req.cmd;
					key_q    <= req.key;
					lo_q     <= '0;
					hi_q     <= count_q;
					found_q  <= 1'b0;
					pos_q    <= '0;
					status_q <= ST_OK;
					if (req.cmd == CMD_INSERT && count_q >= CNT_W'(CAPACITY)) begin
						status_q <= ST_FULL;
					end
					if ((req.cmd == CMD_DELETE || req.cmd == CMD_SEARCH) && count_q == '0) begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_PROBE: begin
				if (lo_q < hi_q) begin
					mid_q <= mid_w;
				end else begin
					slot_q <= lo_q[IDX_W-1:0];
					case (cmd_q)
						CMD_INSERT: begin
							if (found_q) begin
								status_q <= ST_DUP;
							end
							rd_ptr_q <= IDX_W'(count_q - CNT_W'(1));
							stop_q   <= lo_q[IDX_W-1:0];
						end
						CMD_DELETE: begin
							if (!found_q) begin
								status_q <= ST_ABSENT;
							end
							rd_ptr_q <= IDX_W'(lo_plus1);
							stop_q   <= IDX_W'(count_q - CNT_W'(1));
						end
						CMD_SEARCH: begin
							if (found_q) begin
								pos_q <= RPT_W'(lo_plus1);
							end else begin
								status_q <= ST_ABSENT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_CMP: begin
				if (key_lt) begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					hi_q <= CNT_W'(mid_q);
				end
				if (key_eq) begin
					found_q <= 1'b1;
				end
			end
			S_SHIFT: begin
				if (rd_act_q) begin
					if (cmd_q == CMD_INSERT) begin
						addr_s1  <= rd_ptr_q + IDX_W'(1);
						rd_ptr_q <= rd_ptr_q - IDX_W'(1);
					end else begin
						addr_s1  <= rd_ptr_q - IDX_W'(1);
						rd_ptr_q <= rd_ptr_q + IDX_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// the table never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// RAM writes happen only while shifting or placing a key
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (state_q == S_SHIFT || state_q == S_FIN))
		else $error("RAM write outside shift or finish");

	// every compare follows a probe that issued the read
	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_PROBE && $past(ram_rd_en)))
		else $error("compare without a preceding read");

	// search window stays ordered
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE || state_q == S_CMP) |-> (lo_q <= hi_q))
		else $error("search window inverted");

	// entry count changes only on a finish or a clear
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			($past(state_q) == S_FIN || ($past(accept) && count_q == '0)))
		else $error("entry count changed outside finish or clear");

endmodule

FILE: design/sorted_unique_key_table.sv
// Top level of the sorted unique key table: core, key RAM and result register.
//
//  channel | valid     | stall     | payload | moves
//  --------+-----------+-----------+---------+-------------------------------
//  request | req_valid | req_stall | req     | command and key into the table
//  result  | rsp_valid | rsp_stall | rsp     | status, position, entry count
//
// One command at a time. Clear, full and empty answers go from the idle state
// straight to the result state; other commands first run a binary search over
// the key RAM (n keys held), one probe and one compare state per step. An insert
// or delete then moves m RAM entries, one RAM entry moved per cycle, before the
// finish state; m = n - slot on an insert, n - slot - 1 on a delete.
// Reset empties the table at once; the key RAM needs no clearing.
// A stalled result sits in the output register; the next request is taken
// meanwhile, and its result waits until that register frees.
module sorted_unique_key_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sukt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sukt_pkg::rsp_t rsp
);
	import sukt_pkg::*;

	logic             push;
	rsp_t             push_rsp;
	logic             push_ready;
	logic             ram_wr_en;
	logic [IDX_W-1:0] ram_wr_addr;
	logic [KEY_W-1:0] ram_wr_data;
	logic             ram_rd_en;
	logic [IDX_W-1:0] ram_rd_addr;
	logic [KEY_W-1:0] ram_rd_data;

	sukt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.push        (push),
		.push_rsp    (push_rsp),
		.push_ready  (push_ready),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	sukt_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_W),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sukt_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rsp   (push_rsp),
		.push_ready (push_ready),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

FILE: dv/sukt_table_checker.sv
// Checker for the sorted unique key table: watches both channels, predicts each result, compares.
module sukt_table_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  sukt_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  sukt_pkg::rsp_t rsp,
	output int             mismatches,
	output int             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import sukt_pkg::*;

	typedef logic signed [KEY_W-1:0] key_t;

	// Shadow of the table contents, always in ascending order
	key_t shadow_keys[$];
	// Results owed by the block, oldest first
	rsp_t answers_due[$];

	initial mismatches = 0;

	task automatic report_mismatch(input string line);
		$display("%0t ns: mismatch: %s", $time, line);
		mismatches++;
	endtask

	// Apply one command to the shadow table and return the answer it owes
	function automatic rsp_t next_answer(input req_t r);
		rsp_t ans;
		key_t k;
		int slot;
		int held;
		k = r.key;
		held = shadow_keys.size();
		ans.status = ST_OK;
		ans.position = '0;
		// find the first held key not below k
		slot = 0;
		while (slot < held && shadow_keys[slot] < k)
			slot++;
		case (r.cmd)
			CMD_CLEAR: begin
				shadow_keys.delete();
			end
			CMD_INSERT: begin
				if (held >= CAPACITY)
					ans.status = ST_FULL;
				else if (slot < held && shadow_keys[slot] == k)
					ans.status = ST_DUP;
				else
					shadow_keys.insert(slot, k);
			end
			CMD_DELETE: begin
				if (held == 0)
					ans.status = ST_EMPTY;
				else if (slot >= held || shadow_keys[slot] != k)
					ans.status = ST_ABSENT;
				else
					shadow_keys.delete(slot);
			end
			default: begin
				if (held == 0)
					ans.status = ST_EMPTY;
				else if (slot >= held || shadow_keys[slot] != k)
					ans.status = ST_ABSENT;
				else
					ans.position = RPT_W'(slot + 1);
			end
		endcase
		ans.entry_count = RPT_W'(shadow_keys.size());
		return ans;
	endfunction

	// Compare each result transfer, then predict each request transfer
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_keys.delete();
			answers_due.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing due: status %0d pos %0d count %0d",
						rsp.status, rsp.position, rsp.entry_count));
				end else begin
					want = answers_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							rsp.status, want.status));
					if (rsp.position !== want.position)
						report_mismatch($sformatf("position got %0d want %0d",
							rsp.position, want.position));
					if (rsp.entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count got %0d want %0d",
							rsp.entry_count, want.entry_count));
				end
			end
			if (req_valid && !req_stall)
				answers_due.push_back(next_answer(req));
			outstanding <= answers_due.size();
		end
	end

endmodule

FILE: dv/tb_sorted_unique_key_table.sv
// Testbench top for the sorted unique key table: clock, reset, stimulus, receiver stalls, verdict.
module tb_sorted_unique_key_table;
	timeunit 1ns;
	timeprecision 1ps;

	import sukt_pkg::*;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam int   ITEMS       = 1600;
	localparam int   QUIET_LIMIT = 4000;
	localparam int   HOLD_CYCLES = 500;
	localparam key_t KEY_MIN     = key_t'(32'h8000_0000);
	localparam key_t KEY_MAX     = key_t'(32'h7FFF_FFFF);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;
	int sent = 0;
	int burst_left = 0;
	key_t known_keys[$];

	always #2 clk = ~clk;

	sorted_unique_key_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	sukt_table_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one command; open a new burst after a random gap when the last one ran out
	task automatic send(input cmd_t c, input key_t k);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
		req <= '{cmd: c, key: k};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		burst_left--;
		sent++;
		// track keys offered since the last clear, for hits and duplicates
		if (c == CMD_CLEAR)
			known_keys.delete();
		else if (c == CMD_INSERT) begin
			known_keys.push_back(k);
			if (known_keys.size() > 2 * CAPACITY)
				void'(known_keys.pop_front());
		end
	endtask

	function automatic key_t rand_key();
		case ($urandom_range(0, 11))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return key_t'(-1);
			3: return key_t'(0);
			default: return key_t'($urandom);
		endcase
	endfunction

	function automatic key_t pick_known();
		if (known_keys.size() == 0)
			return rand_key();
		return known_keys[$urandom_range(0, known_keys.size() - 1)];
	endfunction

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return CMD_CLEAR;
		else if (r < 40)
			return CMD_INSERT;
		else if (r < 65)
			return CMD_DELETE;
		return CMD_SEARCH;
	endfunction

	// Fill to near or past capacity, poke the table with duplicates and extra keys, then drain, often to empty
	task automatic fill_and_drain();
		int idx;
		int drain;
		key_t k;
		send(CMD_CLEAR, rand_key());
		repeat ($urandom_range(CAPACITY - 4, CAPACITY + 6)) send(CMD_INSERT, rand_key());
		repeat ($urandom_range(2, 5)) send(CMD_INSERT, pick_known());
		repeat ($urandom_range(1, 3)) send(CMD_INSERT, rand_key());
		repeat ($urandom_range(4, 10)) send(CMD_SEARCH, pick_known());
		drain = ($urandom_range(0, 1) == 0) ? known_keys.size()
			: $urandom_range(1, known_keys.size());
		repeat (drain) begin
			idx = $urandom_range(0, known_keys.size() - 1);
			k = known_keys[idx];
			known_keys.delete(idx);
			send(($urandom_range(0, 4) == 0) ? CMD_SEARCH : CMD_DELETE, k);
		end
		send(CMD_DELETE, rand_key());
		send(CMD_SEARCH, rand_key());
	endtask

	// Churn keys from a narrow window so hits and duplicates are common
	task automatic narrow_churn();
		key_t base;
		case ($urandom_range(0, 2))
			0: base = KEY_MIN;
			1: base = key_t'(-8);
			default: base = KEY_MAX - 15;
		endcase
		repeat ($urandom_range(20, 60))
			send(pick_cmd(), base + key_t'($urandom_range(0, 15)));
	endtask

	// Mix known keys and fresh keys under random commands
	task automatic mixed_traffic();
		repeat ($urandom_range(15, 45))
			send(pick_cmd(), ($urandom_range(0, 9) < 6) ? pick_known() : rand_key());
	endtask

	// Stimulus: reset, directed cases, random episodes, drain, verdict
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extremes, duplicate, ranks, misses, clear
		send(CMD_SEARCH, key_t'(5));
		send(CMD_DELETE, key_t'(5));
		send(CMD_INSERT, KEY_MIN);
		send(CMD_INSERT, KEY_MAX);
		send(CMD_INSERT, key_t'(0));
		send(CMD_INSERT, key_t'(-1));
		send(CMD_INSERT, key_t'(1));
		send(CMD_INSERT, KEY_MAX);
		send(CMD_SEARCH, KEY_MIN);
		send(CMD_SEARCH, KEY_MAX);
		send(CMD_SEARCH, key_t'(0));
		send(CMD_SEARCH, key_t'(2));
		send(CMD_DELETE, key_t'(2));
		send(CMD_DELETE, KEY_MIN);
		send(CMD_SEARCH, key_t'(-1));
		send(CMD_DELETE, KEY_MAX);
		send(CMD_INSERT, key_t'(32'h5555_5555));
		send(CMD_INSERT, key_t'(32'hAAAA_AAAA));
		send(CMD_SEARCH, key_t'(32'hAAAA_AAAA));
		send(CMD_CLEAR, key_t'(-1));
		send(CMD_SEARCH, key_t'(-1));
		send(CMD_DELETE, KEY_MIN);
		send(CMD_INSERT, key_t'(7));
		send(CMD_CLEAR, key_t'(0));

		// random episodes
		while (sent < ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: fill_and_drain();
				2, 3, 4: narrow_churn();
				5, 6, 7, 8: mixed_traffic();
				default: repeat ($urandom_range(5, 15))
					send(cmd_t'($urandom_range(0, 3)), key_t'($urandom));
			endcase
		end
		req_valid <= 1'b0;

		// wait for every owed result, then let the block settle
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Receiver stalls: random stretches of none, light and heavy stalling, plus long hold-offs
	always @(posedge clk) begin
		int cycle_no;
		int hold_left;
		int mode;
		int mode_left;
		cycle_no++;
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (cycle_no == 3000 || cycle_no == 30000) begin
			rsp_stall <= 1'b1;
			hold_left = HOLD_CYCLES;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			case (mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				default: rsp_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Watchdog: end the run when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
